[rtl/acpc_pkg.sv]
`default_nettype none

package acpc_pkg;

  localparam int NODES_DEF    = 1024;
  localparam int ALPHABET_DEF = 26;

  localparam int KIND_W   = 2;
  localparam int LETTER_W = 5;
  localparam int TOTAL_W  = 48;
  localparam int MATCH_W  = 32;
  localparam int END_W    = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAT_LETTER = 2'd0,
    KIND_PAT_END    = 2'd1,
    KIND_TXT_LETTER = 2'd2,
    KIND_TXT_END    = 2'd3
  } kind_e;

  // one datapath operation per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_TE,
    OP_PL_RD,
    OP_PL_WR,
    OP_PE_RD,
    OP_PE_WR,
    OP_TL_RD,
    OP_TL_M,
    OP_TL_ADD,
    OP_RB_INIT,
    OP_RB_POP,
    OP_RB_U,
    OP_RB_FU,
    OP_RB_C,
    OP_RB_C2,
    OP_RB_C3
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic let_ok;
    logic drop;
    logic q_empty;
    logic child_zero;
    logic c_last;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

[rtl/acpc_ctrl.sv]
`default_nettype none

module acpc_ctrl import acpc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [KIND_W-1:0] kind_i,
  output logic                   in_stall_o,
  input  wire stat_t             stat_i,
  output cmd_t                   cmd_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_PL_RD, S_PL_WR, S_PE_RD, S_PE_WR, S_TL_RD, S_TL_M, S_TL_ADD,
    S_RB_INIT, S_RB_POP, S_RB_U, S_RB_FU, S_RB_C, S_RB_C2, S_RB_C3
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  always_comb begin
    in_stall_o = (state_q != S_IDLE) ||
                 ((kind_i == KIND_TXT_END) && stat_i.out_busy);
    accept     = in_valid_i && !in_stall_o;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      S_CLR: begin
        cmd_o.op = OP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = OP_ACCEPT;
          case (kind_i)
            KIND_PAT_LETTER: state_d = S_PL_RD;
            KIND_PAT_END:    state_d = S_PE_RD;
            KIND_TXT_LETTER: state_d = S_TL_RD;
            default:         cmd_o.op = OP_TE;
          endcase
        end
      end
      S_PL_RD: begin
        if (!stat_i.let_ok || stat_i.drop) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = OP_PL_RD;
          state_d  = S_PL_WR;
        end
      end
      S_PL_WR: begin
        cmd_o.op = OP_PL_WR;
        state_d  = S_IDLE;
      end
      S_PE_RD: begin
        cmd_o.op = OP_PE_RD;
        state_d  = S_PE_WR;
      end
      S_PE_WR: begin
        cmd_o.op = OP_PE_WR;
        state_d  = S_RB_INIT;
      end
      S_TL_RD: begin
        if (!stat_i.let_ok) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = OP_TL_RD;
          state_d  = S_TL_M;
        end
      end
      S_TL_M: begin
        cmd_o.op = OP_TL_M;
        state_d  = S_TL_ADD;
      end
      S_TL_ADD: begin
        cmd_o.op = OP_TL_ADD;
        state_d  = S_IDLE;
      end
      S_RB_INIT: begin
        cmd_o.op = OP_RB_INIT;
        state_d  = S_RB_POP;
      end
      S_RB_POP: begin
        if (stat_i.q_empty) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = OP_RB_POP;
          state_d  = S_RB_U;
        end
      end
      S_RB_U: begin
        cmd_o.op = OP_RB_U;
        state_d  = S_RB_FU;
      end
      S_RB_FU: begin
        cmd_o.op = OP_RB_FU;
        state_d  = S_RB_C;
      end
      S_RB_C: begin
        cmd_o.op = OP_RB_C;
        state_d  = S_RB_C2;
      end
      S_RB_C2: begin
        cmd_o.op = OP_RB_C2;
        if (!stat_i.child_zero) state_d = S_RB_C3;
        else if (stat_i.c_last) state_d = S_RB_POP;
        else                    state_d = S_RB_C;
      end
      S_RB_C3: begin
        cmd_o.op = OP_RB_C3;
        state_d  = stat_i.c_last ? S_RB_POP : S_RB_C;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/acpc_dp.sv]
`default_nettype none

module acpc_dp import acpc_pkg::*; #(
  parameter int NODES    = NODES_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output stat_t                    stat_o,
  input  wire logic [LETTER_W-1:0] letter_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output logic [TOTAL_W-1:0]       total_matches_o,
  output logic                     table_overflow_o
);

  localparam int TBL = NODES * ALPHABET;
  localparam int NW  = $clog2(NODES);
  localparam int AW  = $clog2(TBL);
  localparam int LW  = $clog2(ALPHABET);

  function automatic logic [AW-1:0] row(input logic [NW-1:0] n, input logic [AW-1:0] col);
    return AW'(n) * AW'(ALPHABET) + col;
  endfunction

  // tables
  logic [NW-1:0]      child_mem [0:TBL-1];
  logic [NW-1:0]      jump_mem  [0:TBL-1];
  logic [NW-1:0]      fail_mem  [0:NODES-1];
  logic [END_W-1:0]   endc_mem  [0:NODES-1];
  logic [MATCH_W-1:0] match_mem [0:NODES-1];
  logic [NW-1:0]      queue_mem [0:NODES-1];

  logic               child_we, jump_we, fail_we, endc_we, match_we, queue_we;
  logic [AW-1:0]      child_wa, child_ra, jump_wa, jump_ra;
  logic [NW-1:0]      child_wd, jump_wd, fail_wd, fail_wa, fail_ra;
  logic [NW-1:0]      endc_wa, endc_ra, match_wa, match_ra, queue_wa, queue_ra, queue_wd;
  logic [END_W-1:0]   endc_wd;
  logic [MATCH_W-1:0] match_wd;

  logic [NW-1:0]      child_rd_q, jump_rd_q, fail_rd_q, queue_rd_q;
  logic [END_W-1:0]   endc_rd_q;
  logic [MATCH_W-1:0] match_rd_q;

  // control state
  logic [NW-1:0]      pn_q, pn_d, tn_q, tn_d;
  logic               drop_q, drop_d, ovf_q, ovf_d;
  logic [NW:0]        used_q, used_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  logic [TOTAL_W-1:0] out_total_q;
  logic               out_ovf_q;

  // walk registers
  logic [LETTER_W-1:0] letter_q;
  logic [NW:0]         head_q, head_d, tail_q, tail_d;
  logic [NW-1:0]       u_q, u_d, fu_q, fu_d, v_q, v_d, f_q, f_d;
  logic [LW-1:0]       c_q, c_d;

  logic                clr_small;
  logic [NW-1:0]       jf;
  logic [TOTAL_W:0]    tsum;
  logic [MATCH_W:0]    msum;
  logic [AW-1:0]       ucol;

  always_comb begin
    clr_small = 32'(clr_q) < NODES;
    jf        = (u_q == '0) ? '0 : jump_rd_q;
    tsum      = {1'b0, total_q} + (TOTAL_W+1)'(match_rd_q);
    msum      = {{(MATCH_W-END_W+1){1'b0}}, endc_rd_q} + {1'b0, match_rd_q};
    ucol      = row(u_q, AW'(c_q));

    stat_o.clr_last   = clr_q == AW'(TBL - 1);
    stat_o.let_ok     = 32'(letter_q) < ALPHABET;
    stat_o.drop       = drop_q;
    stat_o.q_empty    = head_q == tail_q;
    stat_o.child_zero = child_rd_q == '0;
    stat_o.c_last     = 32'(c_q) == ALPHABET - 1;
    stat_o.out_busy   = out_valid_q && out_stall_i;
  end

  // memory ports
  always_comb begin
    child_we = 1'b0;  child_wa = clr_q;  child_wd = '0;
    jump_we  = 1'b0;  jump_wa  = clr_q;  jump_wd  = '0;
    fail_we  = 1'b0;  fail_wa  = clr_q[NW-1:0]; fail_wd  = '0;
    endc_we  = 1'b0;  endc_wa  = clr_q[NW-1:0]; endc_wd  = '0;
    match_we = 1'b0;  match_wa = clr_q[NW-1:0]; match_wd = '0;
    queue_we = 1'b0;  queue_wa = tail_q[NW-1:0]; queue_wd = v_q;
    child_ra = row(pn_q, AW'(letter_q));
    jump_ra  = row(tn_q, AW'(letter_q));
    fail_ra  = queue_rd_q;
    endc_ra  = pn_q;
    match_ra = jump_rd_q;
    queue_ra = head_q[NW-1:0];
    case (cmd_i.op)
      OP_CLEAR: begin
        child_we = 1'b1;
        jump_we  = 1'b1;
        fail_we  = clr_small;
        endc_we  = clr_small;
        match_we = clr_small;
      end
      OP_PL_WR: begin
        child_we = (child_rd_q == '0) && (used_q < (NW+1)'(NODES));
        child_wa = row(pn_q, AW'(letter_q));
        child_wd = used_q[NW-1:0];
      end
      OP_PE_WR: begin
        endc_we = !drop_q && (pn_q != '0) && (endc_rd_q != '1);
        endc_wa = pn_q;
        endc_wd = endc_rd_q + END_W'(1);
      end
      OP_RB_INIT: begin
        fail_we  = 1'b1;
        fail_wa  = '0;
        match_we = 1'b1;
        match_wa = '0;
        queue_we = 1'b1;
        queue_wa = '0;
        queue_wd = '0;
      end
      OP_RB_C: begin
        child_ra = ucol;
        jump_ra  = row(fu_q, AW'(c_q));
      end
      OP_RB_C2: begin
        jump_we  = child_rd_q == '0;
        jump_wa  = ucol;
        jump_wd  = jf;
        endc_ra  = child_rd_q;
        match_ra = jf;
      end
      OP_RB_C3: begin
        jump_we  = 1'b1;
        jump_wa  = ucol;
        jump_wd  = v_q;
        fail_we  = 1'b1;
        fail_wa  = v_q;
        fail_wd  = f_q;
        match_we = 1'b1;
        match_wa = v_q;
        match_wd = msum[MATCH_W] ? '1 : msum[MATCH_W-1:0];
        queue_we = tail_q < (NW+1)'(NODES);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (child_we) child_mem[child_wa] <= child_wd;
    child_rd_q <= child_mem[child_ra];
  end

  always_ff @(posedge clk_i) begin
    if (jump_we) jump_mem[jump_wa] <= jump_wd;
    jump_rd_q <= jump_mem[jump_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    fail_rd_q <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk_i) begin
    if (endc_we) endc_mem[endc_wa] <= endc_wd;
    endc_rd_q <= endc_mem[endc_ra];
  end

  always_ff @(posedge clk_i) begin
    if (match_we) match_mem[match_wa] <= match_wd;
    match_rd_q <= match_mem[match_ra];
  end

  always_ff @(posedge clk_i) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_rd_q <= queue_mem[queue_ra];
  end

  // register updates
  always_comb begin
    pn_d   = pn_q;
    tn_d   = tn_q;
    drop_d = drop_q;
    ovf_d  = ovf_q;
    used_d = used_q;
    total_d = total_q;
    clr_d  = clr_q;
    head_d = head_q;
    tail_d = tail_q;
    u_d    = u_q;
    fu_d   = fu_q;
    v_d    = v_q;
    f_d    = f_q;
    c_d    = c_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (cmd_i.op)
      OP_CLEAR: clr_d = clr_q + AW'(1);
      OP_TE: begin
        out_valid_d = 1'b1;
        total_d     = '0;
        tn_d        = '0;
      end
      OP_PL_WR: begin
        if (child_rd_q != '0) begin
          pn_d = child_rd_q;
        end else if (used_q >= (NW+1)'(NODES)) begin
          drop_d = 1'b1;
          ovf_d  = 1'b1;
        end else begin
          pn_d   = used_q[NW-1:0];
          used_d = used_q + (NW+1)'(1);
        end
      end
      OP_PE_WR: begin
        pn_d   = '0;
        drop_d = 1'b0;
      end
      OP_TL_M: tn_d = jump_rd_q;
      OP_TL_ADD: total_d = tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
      OP_RB_INIT: begin
        head_d = '0;
        tail_d = (NW+1)'(1);
      end
      OP_RB_POP: head_d = head_q + (NW+1)'(1);
      OP_RB_U: begin
        u_d = queue_rd_q;
        c_d = '0;
      end
      OP_RB_FU: fu_d = fail_rd_q;
      OP_RB_C2: begin
        v_d = child_rd_q;
        f_d = jf;
        if (child_rd_q == '0) c_d = c_q + LW'(1);
      end
      OP_RB_C3: begin
        c_d = c_q + LW'(1);
        if (tail_q < (NW+1)'(NODES)) tail_d = tail_q + (NW+1)'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q        <= '0;
      tn_q        <= '0;
      drop_q      <= 1'b0;
      ovf_q       <= 1'b0;
      used_q      <= (NW+1)'(1);
      total_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pn_q        <= pn_d;
      tn_q        <= tn_d;
      drop_q      <= drop_d;
      ovf_q       <= ovf_d;
      used_q      <= used_d;
      total_q     <= total_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACCEPT) letter_q <= letter_i;
    if (cmd_i.op == OP_TE) begin
      out_total_q <= total_q;
      out_ovf_q   <= ovf_q;
    end
    head_q <= head_d;
    tail_q <= tail_d;
    u_q    <= u_d;
    fu_q   <= fu_d;
    v_q    <= v_d;
    f_q    <= f_d;
    c_q    <= c_d;
  end

  assign out_valid_o      = out_valid_q;
  assign total_matches_o  = out_total_q;
  assign table_overflow_o = out_ovf_q;

endmodule

`default_nettype wire

[rtl/aho_corasick_pattern_counter.sv]
// aho_corasick_pattern_counter: online multi-pattern occurrence counter
// input channel (in_valid_i / in_stall_o): one word = kind_i + letter_i;
//   pattern letters grow the trie, a pattern end rebuilds the automaton,
//   text letters step it, a text end emits the running total
// output channel (out_valid_o / out_stall_i): one word per text end with
//   total_matches_o and the sticky table_overflow_o flag
// each table has a single read port, so pattern letters, text letters and
//   pattern ends run as sequences of read and write steps; a pattern end
//   also walks the trie breadth-first to rebuild the fail and jump links
// text end result shows on out_valid_o the cycle after acceptance
// after reset a clearing pass zeroes the tables;
//   in_stall_o stays high during it
// the output register holds a result while out_stall_i is high; other
//   words are still taken, only a further text end waits for it to drain
`default_nettype none

module aho_corasick_pattern_counter import acpc_pkg::*; #(
  parameter int NODES    = NODES_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [KIND_W-1:0]   kind_i,
  input  wire logic [LETTER_W-1:0] letter_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [TOTAL_W-1:0]       total_matches_o,
  output logic                     table_overflow_o
);

  // command / status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  acpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // tables, walk queue, running total and output register
  acpc_dp #(
    .NODES    (NODES),
    .ALPHABET (ALPHABET)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .letter_i         (letter_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .total_matches_o  (total_matches_o),
    .table_overflow_o (table_overflow_o)
  );

endmodule

`default_nettype wire

[rtl/acpc_checker.sv]
`default_nettype none

module acpc_checker import acpc_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic [KIND_W-1:0]   kind_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic                table_overflow_o
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // accepted text end gives a result next cycle
  a_te_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == KIND_TXT_END) |=> out_valid_o)
    else $error("text end without result");

  // overflow flag is sticky
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_overflow_o ##1 out_valid_o |-> table_overflow_o)
    else $error("overflow flag cleared");

  // clearing pass holds off input after reset
  a_clr_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input taken during clearing pass");

endmodule

bind aho_corasick_pattern_counter acpc_checker u_acpc_checker (.*);

`default_nettype wire
